### rtl/assert_macros.svh
// assertion helpers, clocked on i_clk and switched off while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssort_pkg;

    localparam int DATA_W      = 32;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_GAP,
        ST_RD_I,
        ST_HOLD,
        ST_RD_J,
        ST_CMP,
        ST_OUT_RD,
        ST_OUT_EMIT
    } t_state;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } t_mem_req;

endpackage
`default_nettype wire

### rtl/ssort_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module ssort_mem
    import ssort_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mem_req                 i_req,
    output logic signed [DATA_W-1:0]      o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/ssort_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ssort_ctrl
    import ssort_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                     i_last,
    output logic                          o_busy,
    output t_mem_req                      o_mem_req,
    input  wire logic signed [DATA_W-1:0] i_rd_data,
    output logic                          o_strobe,
    output logic signed [DATA_W-1:0]      o_sorted_value,
    output logic                          o_final_res,
    output logic                          o_dropped
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ITEMS);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_ovf, n_ovf;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [ADDR_W-1:0]        r_gap, n_gap;
    logic [CNT_W-1:0]         r_i, n_i;
    logic [CNT_W-1:0]         r_j, n_j;
    logic signed [DATA_W-1:0] r_held, n_held;

    logic [CNT_W-1:0]         gap_ext;
    logic [CNT_W-1:0]         j_back;
    logic [CNT_W-1:0]         count_upd;
    logic                     is_less;

    assign gap_ext = {1'b0, r_gap};
    assign j_back  = r_j - gap_ext;
    // the one data comparator
    assign is_less = r_held < i_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_gap  <= n_gap;
        r_i    <= n_i;
        r_j    <= n_j;
        r_held <= n_held;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_n       = r_n;
        n_gap     = r_gap;
        n_i       = r_i;
        n_j       = r_j;
        n_held    = r_held;
        count_upd = r_count;
        o_mem_req = '{we: 1'b0, waddr: r_j[ADDR_W-1:0], wdata: r_held,
                      raddr: r_i[ADDR_W-1:0]};
        o_busy         = 1'b1;
        o_strobe       = 1'b0;
        o_sorted_value = i_rd_data;
        o_final_res    = 1'b0;
        o_dropped      = r_ovf;

        case (r_state)
            ST_LOAD: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (r_count < CAP) begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_count[ADDR_W-1:0];
                        o_mem_req.wdata = i_value;
                        count_upd       = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = count_upd;
                    if (i_last) begin
                        n_n     = count_upd;
                        n_gap   = count_upd[CNT_W-1:1];
                        n_state = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                n_i = gap_ext;
                n_j = '0;
                if (r_gap == '0) begin
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                if (r_i >= r_n) begin
                    n_gap   = r_gap >> 1;
                    n_state = ST_GAP;
                end else begin
                    o_mem_req.raddr = r_i[ADDR_W-1:0];
                    n_j             = r_i;
                    n_state         = ST_HOLD;
                end
            end
            ST_HOLD: begin
                n_held  = i_rd_data;
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                if (r_j >= gap_ext) begin
                    o_mem_req.raddr = j_back[ADDR_W-1:0];
                    n_state         = ST_CMP;
                end else begin
                    o_mem_req.we = 1'b1;
                    n_i          = r_i + CNT_W'(1);
                    n_state      = ST_RD_I;
                end
            end
            ST_CMP: begin
                o_mem_req.we = 1'b1;
                if (is_less) begin
                    // shift the larger element up by one gap
                    o_mem_req.wdata = i_rd_data;
                    n_j             = j_back;
                    n_state         = ST_RD_J;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_RD_I;
                end
            end
            ST_OUT_RD: begin
                o_mem_req.raddr = r_j[ADDR_W-1:0];
                n_state         = ST_OUT_EMIT;
            end
            ST_OUT_EMIT: begin
                o_strobe    = 1'b1;
                o_final_res = (r_j + CNT_W'(1)) == r_n;
                n_j         = r_j + CNT_W'(1);
                if (o_final_res) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/shell_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Shell sort engine for signed 32-bit values.
// Input: drive i_value and i_last with start; a transfer happens on a clock edge
// where start is high and busy is low. Items arrive one per cycle while loading.
// The item with i_last high closes the set; up to MAX_ITEMS values are kept,
// further ones are discarded and o_dropped is reported with the results.
// After the closing item busy rises while the set is sorted in place with the
// halving gap sequence n/2, n/4 .. 1, using one comparator and one single-port
// read / single-port write store with registered read data.
// Each insertion step reads the element at i into the held register (RD_I,
// HOLD), then per compare reads the element one gap back (RD_J) and, while
// it is larger, moves it up one gap (CMP); the held element is written when
// the walk reaches the front or a compare stops it; a zero gap ends the sort.
// Results in ascending order, each read then shown; o_strobe high for one
// cycle each, o_final_res on the last. The receiver cannot stall; busy falls
// the cycle after the final result and the next set may start.
// Reset (synchronous, active low) empties the set and returns to loading.
module shell_sort_engine
    import ssort_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                     i_last,
    output logic                          o_strobe,
    output logic signed [DATA_W-1:0]      o_sorted_value,
    output logic                          o_final_res,
    output logic                          o_dropped
);

    t_mem_req                 mem_req;
    logic signed [DATA_W-1:0] rd_data;

    ssort_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_busy         (busy),
        .o_mem_req      (mem_req),
        .i_rd_data      (rd_data),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_final_res    (o_final_res),
        .o_dropped      (o_dropped)
    );

    ssort_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

`include "assert_macros.svh"

    `ASSERT_SAME(a_strobe_busy, o_strobe, busy, "result strobe while idle")
    `ASSERT_NEXT(a_final_idle, o_strobe && o_final_res, !busy, "busy after final result")
    `ASSERT_NEXT(a_load_stays, start && !busy && !i_last, !busy, "busy after non-last item")
    `ASSERT_NEXT(a_last_busy, start && !busy && i_last, busy && !o_strobe,
                 "closing item did not start the sort")

endmodule
`default_nettype wire
